FILE: hw/rtl/bcsh_pkg.sv
// bcsh_pkg: shared widths, register indexes, controller states and
// command/status types for the bit crusher with sample-and-hold
// no dependencies
`timescale 1ns / 1ps

package bcsh_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int DEPTH_W     = 5;
    localparam int PHASE_W     = 14;
    localparam int MIX_W       = 9;
    localparam int LEVEL_W     = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 14;

    // quantizer, divider and blend widths
    localparam int Q_W    = LEVEL_W + 1;
    localparam int QUO_W  = SAMPLE_BITS + 1;
    localparam int NUM_W  = Q_W + SAMPLE_BITS - 1;
    localparam int PROD_W = SAMPLE_BITS + LEVEL_W;
    localparam int CNT_W  = $clog2(QUO_W);
    localparam int ACC_W  = SAMPLE_BITS + MIX_W + 2;

    localparam logic [DEPTH_W-1:0] DEPTH_MIN   = DEPTH_W'(1);
    localparam logic [DEPTH_W-1:0] DEPTH_MAX   = DEPTH_W'(16);
    localparam logic [PHASE_W-1:0] PHASE_ONE   = PHASE_W'(256);
    localparam logic [MIX_W-1:0]   MIX_FULL    = MIX_W'(256);

    localparam logic [DEPTH_W-1:0] DEPTH_RESET = DEPTH_W'(8);
    localparam logic [PHASE_W-1:0] STEP_RESET  = PHASE_W'(1024);
    localparam logic [MIX_W-1:0]   MIX_RESET   = MIX_W'(154);

    localparam logic [CFG_IDX_W-1:0] CFG_BIT_DEPTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_STEP = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_WET_MIX   = CFG_IDX_W'(2);

    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QUO_W - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV_INIT,
        ST_DIV,
        ST_HOLD,
        ST_BLEND_A,
        ST_BLEND_B,
        ST_OUT
    } bcsh_state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic div_init;
        logic div_step;
        logic hold;
        logic blend_a;
        logic blend_b;
        logic out_load;
    } bcsh_cmd_t;

    typedef struct packed {
        logic capture;
    } bcsh_status_t;

endpackage

FILE: hw/rtl/bcsh_if.sv
// bcsh_if: sample input, sample output and configuration write channels
// depends on bcsh_pkg
`timescale 1ns / 1ps

interface bcsh_in_if import bcsh_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface bcsh_out_if import bcsh_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

interface bcsh_cfg_if import bcsh_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/bcsh_ctrl.sv
// bcsh_ctrl: sequencer for one request at a time, divider step count and
// output valid flag
// depends on bcsh_pkg
`timescale 1ns / 1ps

module bcsh_ctrl import bcsh_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  bcsh_status_t status,
    output bcsh_cmd_t    cmd
);

    bcsh_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                // capture flag is set by the load
                if (status.capture)
                begin
                    cmd.mul    = 1'b1;
                    state_next = ST_DIV_INIT;
                end
                else
                begin
                    cmd.blend_a = 1'b1;
                    state_next  = ST_BLEND_B;
                end
            end
            ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                cmd.hold   = 1'b1;
                state_next = ST_BLEND_A;
            end
            ST_BLEND_A:
            begin
                cmd.blend_a = 1'b1;
                state_next  = ST_BLEND_B;
            end
            ST_BLEND_B:
            begin
                cmd.blend_b = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

FILE: hw/rtl/bcsh_datapath.sv
// bcsh_datapath: config registers, phase counter, quantizer multiply,
// serial restoring divider, held value and dry/wet blend
// depends on bcsh_pkg and bcsh_if
`timescale 1ns / 1ps

module bcsh_datapath import bcsh_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    bcsh_cfg_if.sink                      cfg,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    output logic signed [SAMPLE_BITS-1:0] sample_out,
    input  bcsh_cmd_t                     cmd,
    output bcsh_status_t                  status
);

    localparam logic [PROD_W-1:0] HALF_LSB  = PROD_W'(1) << (SAMPLE_BITS - 2);
    localparam logic [QUO_W-1:0]  POS_MAX_Q = QUO_W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic [QUO_W-1:0]  NEG_MAG_Q = QUO_W'(1) << (SAMPLE_BITS - 1);
    localparam logic [ACC_W-1:0]  RND_HALF  = ACC_W'(128);
    localparam logic [ACC_W-9:0]  POS_MAX_R = (ACC_W-8)'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic [ACC_W-9:0]  NEG_MAG_R = (ACC_W-8)'(1) << (SAMPLE_BITS - 1);
    localparam logic signed [SAMPLE_BITS-1:0] POS_MAX_S =
        SAMPLE_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [SAMPLE_BITS-1:0] NEG_MIN_S =
        SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);

    logic [DEPTH_W-1:0]            bit_depth_reg;
    logic [PHASE_W-1:0]            hold_step_reg;
    logic [MIX_W-1:0]              wet_mix_reg;
    logic [PHASE_W-1:0]            phase_reg, phase_next;
    logic                          capture_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic signed [SAMPLE_BITS-1:0] held_reg, held_next;
    logic                          neg_reg;
    logic [PROD_W-1:0]             prod_reg;
    logic [LEVEL_W-1:0]            rem_reg, rem_next;
    logic [QUO_W-1:0]              quo_reg;
    logic signed [ACC_W-1:0]       acc_reg;
    logic signed [SAMPLE_BITS-1:0] out_reg, out_next;

    logic [DEPTH_W-1:0]            bits_c;
    logic [LEVEL_W:0]              one_sh;
    logic [LEVEL_W-1:0]            levels_c;
    logic [PHASE_W-1:0]            step_c;
    logic [MIX_W-1:0]              mix_c;
    logic [MIX_W-1:0]              dry_w;
    logic [PHASE_W:0]              ph_sum;
    logic                          take_c;
    logic [SAMPLE_BITS-1:0]        mag_c;
    logic [PROD_W-1:0]             q_full;
    logic [Q_W-1:0]                q_c;
    logic [NUM_W-1:0]              num_c;
    logic [LEVEL_W:0]              trial;
    logic                          ge_c;
    logic [LEVEL_W:0]              trial_sub;
    logic signed [MIX_W:0]         mix_s;
    logic signed [MIX_W:0]         dry_s;
    logic signed [SAMPLE_BITS+MIX_W:0] wet_prod;
    logic signed [SAMPLE_BITS+MIX_W:0] dry_prod;
    logic                          acc_neg;
    logic [ACC_W-1:0]              acc_mag;
    logic [ACC_W-1:0]              rnd_sum;
    logic [ACC_W-9:0]              rnd;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_depth_reg <= DEPTH_RESET;
            hold_step_reg <= STEP_RESET;
            wet_mix_reg   <= MIX_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_BIT_DEPTH: bit_depth_reg <= cfg.data[DEPTH_W-1:0];
                CFG_HOLD_STEP: hold_step_reg <= cfg.data[PHASE_W-1:0];
                CFG_WET_MIX:   wet_mix_reg   <= cfg.data[MIX_W-1:0];
                default:       ;
            endcase
        end
    end

    // clamped register values
    always_comb
    begin
        if (bit_depth_reg < DEPTH_MIN)
            bits_c = DEPTH_MIN;
        else if (bit_depth_reg > DEPTH_MAX)
            bits_c = DEPTH_MAX;
        else
            bits_c = bit_depth_reg;
        one_sh   = (LEVEL_W+1)'(1) << bits_c;
        levels_c = one_sh[LEVEL_W-1:0] - LEVEL_W'(1);
        step_c   = (hold_step_reg < PHASE_ONE) ? PHASE_ONE : hold_step_reg;
        mix_c    = (wet_mix_reg > MIX_FULL) ? MIX_FULL : wet_mix_reg;
        dry_w    = MIX_FULL - mix_c;
    end

    // phase counter
    always_comb
    begin
        ph_sum = {1'b0, phase_reg} + {1'b0, PHASE_ONE};
        take_c = (ph_sum >= {1'b0, step_c});
        if (take_c)
            ph_sum = ph_sum - {1'b0, step_c};
        phase_next = ph_sum[PHASE_W-1:0];
    end

    // quantizer and divider
    always_comb
    begin
        mag_c     = sample_reg[SAMPLE_BITS-1] ? (~sample_reg + SAMPLE_BITS'(1)) : sample_reg;
        q_full    = (prod_reg + HALF_LSB) >> (SAMPLE_BITS - 1);
        q_c       = q_full[Q_W-1:0];
        num_c     = {q_c, {(SAMPLE_BITS-1){1'b0}}} + NUM_W'(levels_c >> 1);
        trial     = {rem_reg, quo_reg[QUO_W-1]};
        ge_c      = (trial >= {1'b0, levels_c});
        trial_sub = trial - {1'b0, levels_c};
        rem_next  = ge_c ? trial_sub[LEVEL_W-1:0] : trial[LEVEL_W-1:0];
    end

    // scale-back result with sign and saturation
    always_comb
    begin
        if (!neg_reg)
            held_next = (quo_reg > POS_MAX_Q) ? POS_MAX_S : quo_reg[SAMPLE_BITS-1:0];
        else if (quo_reg > NEG_MAG_Q)
            held_next = NEG_MIN_S;
        else
            held_next = -quo_reg[SAMPLE_BITS-1:0];
    end

    // blend and rounding
    always_comb
    begin
        mix_s    = {1'b0, mix_c};
        dry_s    = {1'b0, dry_w};
        wet_prod = held_reg * mix_s;
        dry_prod = sample_reg * dry_s;
        acc_neg  = acc_reg[ACC_W-1];
        acc_mag  = acc_neg ? -acc_reg : acc_reg;
        rnd_sum  = acc_mag + RND_HALF;
        rnd      = rnd_sum[ACC_W-1:8];
        if (!acc_neg)
            out_next = (rnd > POS_MAX_R) ? POS_MAX_S : rnd[SAMPLE_BITS-1:0];
        else if (rnd > NEG_MAG_R)
            out_next = NEG_MIN_S;
        else
            out_next = -rnd[SAMPLE_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= '0;
            held_reg    <= '0;
            capture_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                phase_reg   <= phase_next;
                capture_reg <= take_c;
            end
            if (cmd.hold)
                held_reg <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            sample_reg <= sample_in;
        if (cmd.mul)
        begin
            neg_reg  <= sample_reg[SAMPLE_BITS-1];
            prod_reg <= PROD_W'(mag_c) * PROD_W'(levels_c);
        end
        if (cmd.div_init)
        begin
            rem_reg <= LEVEL_W'(num_c[NUM_W-1:QUO_W]);
            quo_reg <= num_c[QUO_W-1:0];
        end
        if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[QUO_W-2:0], ge_c};
        end
        if (cmd.blend_a)
            acc_reg <= ACC_W'(wet_prod);
        if (cmd.blend_b)
            acc_reg <= acc_reg + ACC_W'(dry_prod);
        if (cmd.out_load)
            out_reg <= out_next;
    end

    assign status.capture = capture_reg;
    assign sample_out     = out_reg;

endmodule

FILE: hw/rtl/bit_crusher_sample_hold.sv
// channel  dir   payload              handshake
// din      in    sample_in [15:0] s   valid/ready, one request per item
// dout     out   sample_out [15:0] s  valid/ready, registered
// cfg      in    index [1:0], data    valid/ready, ready always high
//
// a request without a new hold value goes from accept through the blend steps to the
// output load; one with a capture first runs the multiply, the 17-step restoring divider
// and the hold update; the next request is taken in the cycle after the result is loaded
// one request is in work at a time; the output register holds a result
// while the next request is accepted and processed
// a stalled output holds the sequencer in its last state until taken
// reset clears config to defaults, phase and held value to zero
// depends on bcsh_pkg, bcsh_if, bcsh_ctrl and bcsh_datapath
`timescale 1ns / 1ps

module bit_crusher_sample_hold import bcsh_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    bcsh_in_if.sink   din,
    bcsh_out_if.source dout,
    bcsh_cfg_if.sink  cfg
);

    bcsh_cmd_t    cmd;
    bcsh_status_t status;
    logic         in_ready;
    logic         out_valid;

    bcsh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (din.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (dout.ready),
        .status    (status),
        .cmd       (cmd)
    );

    bcsh_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .sample_in  (din.sample_in),
        .sample_out (dout.sample_out),
        .cmd        (cmd),
        .status     (status)
    );

    assign din.ready  = in_ready;
    assign dout.valid = out_valid;

    // one request in work at a time
    a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
        din.valid && din.ready |=> !din.ready)
        else $error("request accepted while another is in work");

    // divider runs its full step count before the hold update
    a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.hold |-> $past(cmd.div_step) && $past(u_ctrl.cnt_reg) == DIV_LAST)
        else $error("hold update without a complete divide");

    // a result is never loaded over one that waits
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !dout.valid || dout.ready)
        else $error("output overwritten while stalled");

    // at most one of the blend, divider step and multiply commands per cycle
    a_acc_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.blend_a, cmd.blend_b, cmd.div_step, cmd.mul}))
        else $error("conflicting datapath commands");

endmodule
